// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define USV_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Check that a condition on one edge implies another on the next edge.
`define USV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/usv_pkg.sv
package usv_pkg;

  localparam logic [7:0] LEAD_BIT      = 8'h80;
  localparam logic [7:0] CONT_MASK     = 8'hC0;
  localparam logic [7:0] CONT_PATTERN  = 8'h80;
  localparam logic [7:0] LEAD2_MASK    = 8'hE0;
  localparam logic [7:0] LEAD2_PATTERN = 8'hC0;
  localparam logic [7:0] LEAD3_MASK    = 8'hF0;
  localparam logic [7:0] LEAD3_PATTERN = 8'hE0;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [1:0] pend;
    logic       err;
  } dec_state_t;

endpackage

// File: design/usv_step.sv
module usv_step (
  input  logic [7:0]            text_byte,
  input  usv_pkg::dec_state_t   cur,
  output usv_pkg::dec_state_t   nxt,
  output logic                  ok
);

  logic is_cont;
  logic is_ascii;
  logic is_lead2;
  logic is_lead3;

  assign is_cont  = (text_byte & usv_pkg::CONT_MASK) == usv_pkg::CONT_PATTERN;
  assign is_ascii = (text_byte & usv_pkg::LEAD_BIT) == 8'h00;
  assign is_lead2 = (text_byte & usv_pkg::LEAD2_MASK) == usv_pkg::LEAD2_PATTERN;
  assign is_lead3 = (text_byte & usv_pkg::LEAD3_MASK) == usv_pkg::LEAD3_PATTERN;

  always_comb begin
    nxt = cur;
    priority if (cur.err) begin
      nxt = cur;
    end else if (cur.pend != usv_pkg::PEND_NONE) begin
      if (is_cont) begin
        nxt.pend = cur.pend - 2'd1;
      end else begin
        nxt.err  = 1'b1;
        nxt.pend = usv_pkg::PEND_NONE;
      end
    end else if (is_ascii) begin
      nxt = cur;
    end else if (is_lead2) begin
      nxt.pend = usv_pkg::PEND_ONE;
    end else if (is_lead3) begin
      nxt.pend = usv_pkg::PEND_TWO;
    end else begin
      // stray continuation or four-byte-or-longer lead
      nxt.err = 1'b1;
    end
  end

  assign ok = !nxt.err && (nxt.pend == usv_pkg::PEND_NONE);

endmodule

// File: design/utf8_sequence_validator.sv
// UTF-8 sequence checker for characters of one to three bytes.
// Input channel: in_valid / in_stall carry one string byte per transaction
// (in_text_byte) plus in_final_byte, which marks the last byte of a string.
// Result channel: out_valid / out_stall carry one transaction per string,
// out_is_valid = 1 when every character was a well-formed 1..3 byte form.
// Non-final bytes produce no result transaction.
// Throughput: one byte per cycle while in_stall is low; the per-byte
// decoder state update is a handful of gates between the state registers
// and the result register. The result of a final byte is registered in the
// output register, or in the skid register while the output is held.
// Stall: an output register plus a one-entry skid register let the block
// keep taking bytes while a result waits; in_stall rises only when both
// hold a result, and in_stall is a register output.
// Reset (rst_n low, synchronous): decoder state returns to no pending
// continuation and no error, and both result slots empty. The decoder also
// returns to that state after every final byte.
module utf8_sequence_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_valid
);

`include "assert_macros.svh"

  usv_pkg::dec_state_t state_r;
  usv_pkg::dec_state_t state_nxt;
  usv_pkg::dec_state_t step_nxt;
  logic                step_ok;

  logic out_valid_r, out_valid_nxt;
  logic out_ok_r, out_ok_nxt;
  logic skid_valid_r, skid_valid_nxt;
  logic skid_ok_r, skid_ok_nxt;

  logic in_take;
  logic res_new;
  logic out_free;

  usv_step u_step (
    .text_byte (in_text_byte),
    .cur       (state_r),
    .nxt       (step_nxt),
    .ok        (step_ok)
  );

  assign in_take  = in_valid && !skid_valid_r;
  assign res_new  = in_take && in_final_byte;
  // output slot can take a new value this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    if (in_take) begin
      if (in_final_byte) begin
        // clear decoder state at string end
        state_nxt.pend = usv_pkg::PEND_NONE;
        state_nxt.err  = 1'b0;
      end else begin
        state_nxt = step_nxt;
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_ok_nxt     = out_ok_r;
    skid_valid_nxt = skid_valid_r;
    skid_ok_nxt    = skid_ok_r;
    if (out_free) begin
      if (skid_valid_r) begin
        // drain the skid entry first; no new result can arrive meanwhile
        out_valid_nxt  = 1'b1;
        out_ok_nxt     = skid_ok_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_new;
        out_ok_nxt    = step_ok;
      end
    end else if (res_new) begin
      // output held by the receiver: park the result
      skid_valid_nxt = 1'b1;
      skid_ok_nxt    = step_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.pend <= usv_pkg::PEND_NONE;
      state_r.err  <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_ok_r  <= out_ok_nxt;
    skid_ok_r <= skid_ok_nxt;
  end

  assign in_stall     = skid_valid_r;
  assign out_valid    = out_valid_r;
  assign out_is_valid = out_ok_r;

  // At most two continuation bytes are ever owed.
  `USV_ASSERT(a_pend_range, state_r.pend != 2'd3)
  // Skid entry only fills behind a waiting output.
  `USV_ASSERT(a_skid_behind_out, !skid_valid_r || out_valid_r)
  // A final byte leaves the decoder clean.
  `USV_ASSERT_NEXT(a_final_clears, in_take && in_final_byte,
                   state_r.pend == usv_pkg::PEND_NONE && !state_r.err)
  // A released output with a parked result moves it up at once.
  `USV_ASSERT_NEXT(a_skid_drain, skid_valid_r && !out_stall,
                   out_valid_r && !skid_valid_r)

endmodule
